// ----- rtl/core/assert_macros.svh -----
// Assertion helpers: clocked on clock; MFVN_ASSERT is quiet while reset is high, MFVN_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MFVN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define MFVN_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/mfvn_pkg.sv -----
`default_nettype none

package mfvn_pkg;

   localparam int INDEX_BITS  = 10;
   localparam int POS_BITS    = 24;
   localparam int ACC_BITS    = 24;
   localparam int NORMAL_BITS = 16;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_LOAD     = 2'd0;
   localparam opcode_type OP_TRIANGLE = 2'd1;
   localparam opcode_type OP_READ     = 2'd2;

   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/mesh_face_vertex_normals_top.sv -----
// Face and summed vertex normals of a triangle mesh. A word is accepted when start is high
// and busy is low. A vertex load leaves busy low and gives no result. A triangle reads its
// three positions, takes the edge differences, forms the cross product on one shared
// multiplier, takes magnitudes, scales the vector down one bit a cycle until it fits 30
// bits, sums the squares, takes the square root one result bit a cycle, loads the
// dividers, divides all three components one quotient bit a cycle, emits the face normal
// and then updates the three corner accumulators with a read and a write each. A vertex
// normal read takes the accumulator read, magnitudes, one scaling check and the same
// square root, division and emit steps. A zero vector skips straight to the result. Each
// result shows on the rsp_ ports for one cycle with rsp_valid high; the receiver cannot
// stall it, so it must take every word. After reset the block clears every entry of the
// accumulator memory with busy high.
`default_nettype none

`include "assert_macros.svh"

module mesh_face_vertex_normals_top #(
   parameter int VERTEX_COUNT     = 1024,
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        start,
   output logic                                             busy,
   input  wire mfvn_pkg::opcode_type                        req_opcode,
   input  wire logic [mfvn_pkg::INDEX_BITS-1:0]             req_vertex_index,
   input  wire logic [mfvn_pkg::INDEX_BITS-1:0]             req_corner_b,
   input  wire logic [mfvn_pkg::INDEX_BITS-1:0]             req_corner_c,
   input  wire logic signed [mfvn_pkg::POS_BITS-1:0]        req_pos_x,
   input  wire logic signed [mfvn_pkg::POS_BITS-1:0]        req_pos_y,
   input  wire logic signed [mfvn_pkg::POS_BITS-1:0]        req_pos_z,
   output logic                                             rsp_valid,
   output logic signed [mfvn_pkg::NORMAL_BITS-1:0]          rsp_normal_x,
   output logic signed [mfvn_pkg::NORMAL_BITS-1:0]          rsp_normal_y,
   output logic signed [mfvn_pkg::NORMAL_BITS-1:0]          rsp_normal_z,
   output logic                                             rsp_is_degenerate,
   output logic                                             rsp_result_kind
);

   localparam int AW   = $clog2(VERTEX_COUNT);
   localparam int CB   = COORD_BITS;
   localparam int CBE  = CB + 1;
   localparam int DS   = (CB > 30) ? CB - 30 : 0;
   localparam int DW   = CBE - DS;
   localparam int PW   = 2 * DW;
   localparam int VW   = PW + 1;
   localparam int NVW  = (VW > 25) ? VW : 25;
   localparam int MW   = (NVW > 30) ? NVW : 30;
   localparam int F    = NORMAL_FRAC_BITS;
   localparam int QW   = F + 1;
   localparam int NBW  = 31 + F;
   localparam int SW   = 62;
   localparam int IB   = mfvn_pkg::INDEX_BITS;
   localparam int AB   = mfvn_pkg::ACC_BITS;
   localparam int OB   = mfvn_pkg::NORMAL_BITS;

   typedef enum logic [14:0] {
      ST_CLEAR = 15'b000000000000001,
      ST_IDLE  = 15'b000000000000010,
      ST_PRD   = 15'b000000000000100,
      ST_EDGE  = 15'b000000000001000,
      ST_CROSS = 15'b000000000010000,
      ST_ARD   = 15'b000000000100000,
      ST_MAG   = 15'b000000001000000,
      ST_SHIFT = 15'b000000010000000,
      ST_SQ    = 15'b000000100000000,
      ST_SQRT  = 15'b000001000000000,
      ST_DLOAD = 15'b000010000000000,
      ST_DIV   = 15'b000100000000000,
      ST_FIN   = 15'b001000000000000,
      ST_URD   = 15'b010000000000000,
      ST_UWR   = 15'b100000000000000
   } state_type;

   function automatic logic [AW-1:0] wrap_index(input logic [IB-1:0] raw);
      logic [IB-1:0] x;
      longint lim;
      x = raw;
      for (int k = IB - 1; k >= 0; k--) begin
         lim = longint'(VERTEX_COUNT) << k;
         if (longint'(x) >= lim) x = x - IB'(lim);
      end
      return AW'(x);
   endfunction

   function automatic logic signed [DW-1:0] edge_diff(input logic signed [CB-1:0] b,
                                                      input logic signed [CB-1:0] a);
      logic signed [CB:0] d;
      logic [CB:0] m;
      d = CBE'(b) - CBE'(a);
      m = d[CB] ? $unsigned(-d) : $unsigned(d);
      m = m >> DS;
      return DW'(d[CB] ? -m : m);
   endfunction

   function automatic logic signed [AB-1:0] sat_add(input logic signed [AB-1:0] acc,
                                                    input logic signed [QW-1:0] n);
      logic signed [32:0] s;
      s = 33'(acc) + 33'(n);
      if (s > 33'sd8388607) s = 33'sd8388607;
      if (s < -33'sd8388608) s = -33'sd8388608;
      return s[AB-1:0];
   endfunction

   function automatic logic signed [QW-1:0] final_norm(input logic [QW-1:0] q,
                                                       input logic neg);
      logic [QW-1:0] c;
      c = q[QW-1] ? {1'b0, {F{1'b1}}} : q;
      return $signed(neg ? -c : c);
   endfunction

   function automatic logic [OB-1:0] to_out(input logic signed [QW-1:0] n);
      logic signed [31:0] w;
      w = 32'(n);
      return w[OB-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] ia_ff, ia_in, ib_ff, ib_in, ic_ff, ic_in;
   logic kind_ff, kind_in;
   logic deg_ff, deg_in;
   logic [3*CB-1:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic signed [DW-1:0] e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [NVW-1:0] vec_ff [3], vec_in [3];
   logic [MW-1:0] mag_ff [3], mag_in [3];
   logic neg_ff [3], neg_in [3];
   logic [59:0] sq_ff, sq_in;
   logic [SW-1:0] sum_ff, sum_in, x_ff, x_in, res_ff, res_in, sbit_ff, sbit_in;
   logic [30:0] r_ff, r_in;
   logic [30:0] rem_ff [3], rem_in [3];
   logic [QW-1:0] quo_ff [3], quo_in [3];
   logic signed [QW-1:0] n_ff [3], n_in [3];
   logic valid_ff, valid_in;
   logic [OB-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic odeg_ff, odeg_in, okind_ff, okind_in;

   logic [3*CB-1:0] pos_mem [VERTEX_COUNT];
   logic [3*AB-1:0] acc_mem [VERTEX_COUNT];
   logic [3*CB-1:0] pos_rd_ff, pos_wd;
   logic [3*AB-1:0] acc_rd_ff, acc_wd;
   logic pos_we, acc_we;
   logic [AW-1:0] pos_wa, pos_ra, acc_wa, acc_ra;

   logic [AW-1:0] req_a;
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic [29:0] sq_a;
   logic [59:0] sq_p;
   logic accept;
   logic [SW-1:0] root_try, res_next;
   logic [AW-1:0] corner;
   logic [NBW-1:0] num;
   logic signed [QW-1:0] fin_n;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);
   assign req_a  = wrap_index(req_vertex_index);
   assign mul_p  = mul_a * mul_b;
   assign sq_p   = 60'(sq_a) * 60'(sq_a);

   assign rsp_valid         = valid_ff;
   assign rsp_normal_x      = ox_ff;
   assign rsp_normal_y      = oy_ff;
   assign rsp_normal_z      = oz_ff;
   assign rsp_is_degenerate = odeg_ff;
   assign rsp_result_kind   = okind_ff;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    corner = ia_ff;
         2'd1:    corner = ib_ff;
         default: corner = ic_ff;
      endcase
   end

   always_comb begin
      unique case (cnt_ff)
         5'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         5'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         5'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         5'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         5'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         default: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
      endcase
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    sq_a = mag_ff[0][29:0];
         2'd1:    sq_a = mag_ff[1][29:0];
         default: sq_a = mag_ff[2][29:0];
      endcase
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    pos_ra = ia_ff;
         2'd1:    pos_ra = ib_ff;
         default: pos_ra = ic_ff;
      endcase
   end

   always_comb begin
      pos_wa = req_a;
      pos_we = accept && (req_opcode == mfvn_pkg::OP_LOAD);
      pos_wd = {CB'(req_pos_x), CB'(req_pos_y), CB'(req_pos_z)};
   end

   assign root_try = res_ff + sbit_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      ic_in    = ic_ff;
      kind_in  = kind_ff;
      deg_in   = deg_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      pc_in    = pc_ff;
      prod_in  = prod_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      res_in   = res_ff;
      sbit_in  = sbit_ff;
      r_in     = r_ff;
      valid_in = 1'b0;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oz_in    = oz_ff;
      odeg_in  = odeg_ff;
      okind_in = okind_ff;
      res_next = res_ff >> 1;
      num      = NBW'(0);
      fin_n    = QW'(0);
      acc_we   = 1'b0;
      acc_wa   = clr_ff;
      acc_wd   = '0;
      acc_ra   = (state_ff == ST_IDLE) ? req_a : corner;
      for (int i = 0; i < 3; i++) begin
         e1_in[i]  = e1_ff[i];
         e2_in[i]  = e2_ff[i];
         vec_in[i] = vec_ff[i];
         mag_in[i] = mag_ff[i];
         neg_in[i] = neg_ff[i];
         rem_in[i] = rem_ff[i];
         quo_in[i] = quo_ff[i];
         n_in[i]   = n_ff[i];
      end

      unique case (state_ff)
         ST_CLEAR: begin
            acc_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(VERTEX_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               ia_in  = req_a;
               ib_in  = wrap_index(req_corner_b);
               ic_in  = wrap_index(req_corner_c);
               cnt_in = 5'd0;
               priority if (req_opcode == mfvn_pkg::OP_LOAD) begin
                  acc_we = 1'b1;
                  acc_wa = req_a;
               end else if (req_opcode == mfvn_pkg::OP_TRIANGLE) begin
                  kind_in  = mfvn_pkg::KIND_FACE;
                  state_in = ST_PRD;
               end else if (req_opcode == mfvn_pkg::OP_READ) begin
                  kind_in  = mfvn_pkg::KIND_VERTEX;
                  state_in = ST_ARD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PRD: begin
            cnt_in = cnt_ff + 5'd1;
            unique case (cnt_ff)
               5'd1:    pa_in = pos_rd_ff;
               5'd2:    pb_in = pos_rd_ff;
               5'd3:    begin pc_in = pos_rd_ff; state_in = ST_EDGE; end
               default: pa_in = pa_ff;
            endcase
         end
         ST_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i]  = edge_diff(pb_ff[(2-i)*CB +: CB], pa_ff[(2-i)*CB +: CB]);
               e2_in[i]  = edge_diff(pc_ff[(2-i)*CB +: CB], pa_ff[(2-i)*CB +: CB]);
               vec_in[i] = NVW'(0);
            end
            cnt_in   = 5'd0;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            prod_in = mul_p;
            cnt_in  = cnt_ff + 5'd1;
            unique case (cnt_ff)
               5'd1:    vec_in[0] = vec_ff[0] + NVW'(prod_ff);
               5'd2:    vec_in[0] = vec_ff[0] - NVW'(prod_ff);
               5'd3:    vec_in[1] = vec_ff[1] + NVW'(prod_ff);
               5'd4:    vec_in[1] = vec_ff[1] - NVW'(prod_ff);
               5'd5:    vec_in[2] = vec_ff[2] + NVW'(prod_ff);
               5'd6:    begin
                  vec_in[2] = vec_ff[2] - NVW'(prod_ff);
                  state_in  = ST_MAG;
               end
               default: vec_in[0] = vec_ff[0];
            endcase
         end
         ST_ARD: begin
            vec_in[0] = NVW'($signed(acc_rd_ff[3*AB-1:2*AB]));
            vec_in[1] = NVW'($signed(acc_rd_ff[2*AB-1:AB]));
            vec_in[2] = NVW'($signed(acc_rd_ff[AB-1:0]));
            state_in  = ST_MAG;
         end
         ST_MAG: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = vec_ff[i][NVW-1];
               mag_in[i] = MW'(vec_ff[i][NVW-1] ? $unsigned(-vec_ff[i])
                                                : $unsigned(vec_ff[i]));
            end
            if (vec_ff[0] == NVW'(0) && vec_ff[1] == NVW'(0) && vec_ff[2] == NVW'(0)) begin
               deg_in   = 1'b1;
               state_in = ST_FIN;
            end else begin
               deg_in   = 1'b0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (|(mag_ff[0] >> 30) || |(mag_ff[1] >> 30) || |(mag_ff[2] >> 30)) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else begin
               cnt_in   = 5'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in  = sq_p;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd0) sum_in = SW'(0);
            else sum_in = sum_ff + SW'(sq_ff);
            if (cnt_ff == 5'd3) begin
               x_in     = sum_ff + SW'(sq_ff);
               res_in   = SW'(0);
               sbit_in  = SW'(1) << 60;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (x_ff >= root_try) begin
               x_in     = x_ff - root_try;
               res_next = (res_ff >> 1) + sbit_ff;
            end
            res_in  = res_next;
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) begin
               r_in     = (res_next == SW'(0)) ? 31'd1 : res_next[30:0];
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            for (int i = 0; i < 3; i++) begin
               num       = (NBW'(mag_ff[i][29:0]) << F) + NBW'(r_ff >> 1);
               rem_in[i] = 31'(num >> QW);
               quo_in[i] = num[QW-1:0];
            end
            cnt_in   = 5'(F);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if ({rem_ff[i], quo_ff[i][QW-1]} >= {1'b0, r_ff}) begin
                  rem_in[i] = 31'({rem_ff[i], quo_ff[i][QW-1]} - {1'b0, r_ff});
                  quo_in[i] = {quo_ff[i][QW-2:0], 1'b1};
               end else begin
                  rem_in[i] = {rem_ff[i][29:0], quo_ff[i][QW-1]};
                  quo_in[i] = {quo_ff[i][QW-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = ST_FIN;
         end
         ST_FIN: begin
            for (int i = 0; i < 3; i++) begin
               fin_n   = deg_ff ? QW'(0) : final_norm(quo_ff[i], neg_ff[i]);
               n_in[i] = fin_n;
            end
            valid_in = 1'b1;
            ox_in    = to_out(n_in[0]);
            oy_in    = to_out(n_in[1]);
            oz_in    = to_out(n_in[2]);
            odeg_in  = deg_ff;
            okind_in = kind_ff;
            cnt_in   = 5'd0;
            state_in = (kind_ff == mfvn_pkg::KIND_FACE) ? ST_URD : ST_IDLE;
         end
         ST_URD: begin
            state_in = ST_UWR;
         end
         ST_UWR: begin
            acc_we = 1'b1;
            acc_wa = corner;
            acc_wd = {sat_add(acc_rd_ff[3*AB-1:2*AB], n_ff[0]),
                      sat_add(acc_rd_ff[2*AB-1:AB], n_ff[1]),
                      sat_add(acc_rd_ff[AB-1:0], n_ff[2])};
            cnt_in = cnt_ff + 5'd1;
            state_in = (cnt_ff == 5'd2) ? ST_IDLE : ST_URD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      pos_rd_ff <= pos_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      acc_rd_ff <= acc_mem[acc_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= AW'(0);
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         valid_ff <= valid_in;
      end
      cnt_ff   <= cnt_in;
      ia_ff    <= ia_in;
      ib_ff    <= ib_in;
      ic_ff    <= ic_in;
      kind_ff  <= kind_in;
      deg_ff   <= deg_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      pc_ff    <= pc_in;
      prod_ff  <= prod_in;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
      x_ff     <= x_in;
      res_ff   <= res_in;
      sbit_ff  <= sbit_in;
      r_ff     <= r_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      oz_ff    <= oz_in;
      odeg_ff  <= odeg_in;
      okind_ff <= okind_in;
      for (int i = 0; i < 3; i++) begin
         e1_ff[i]  <= e1_in[i];
         e2_ff[i]  <= e2_in[i];
         vec_ff[i] <= vec_in[i];
         mag_ff[i] <= mag_in[i];
         neg_ff[i] <= neg_in[i];
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
         n_ff[i]   <= n_in[i];
      end
   end

   `MFVN_ASSERT(a_strobe_single, rsp_valid |=> !rsp_valid, "result strobe held two cycles")
   `MFVN_ASSERT(a_load_one_cycle, start && !busy && req_opcode == mfvn_pkg::OP_LOAD |=> !busy, "vertex load kept block busy")
   `MFVN_ASSERT(a_degen_zero, rsp_valid && rsp_is_degenerate |-> rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0, "degenerate result with nonzero normal")
   `MFVN_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result strobe after reset")

endmodule

`default_nettype wire
